### sv/irc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_pkg
// Shared types, constants and tables of the isolated ridge correction pipe.
// ----------------------------------------------------------------------------
package irc_pkg;

  // pipeline stage numbering
  localparam int StgIn      = 1;
  localparam int StgCurve   = 2;
  localparam int RootFirst  = 3;
  localparam int RootSlices = 5;
  localparam int RootSteps  = 4;
  localparam int StgSide    = RootFirst + 1;
  localparam int StgMul     = RootFirst + RootSlices;
  localparam int StgSum     = StgMul + 1;
  localparam int StgDiv     = StgMul + 2;
  localparam int NumStages  = StgMul + 3;

  // config register index (byte address bit 2)
  localparam logic RegIdxV2 = 1'b0;

  // distances in km, 8 fraction bits
  localparam logic [15:0] D1LowQ8   = 16'd3840;
  localparam logic [15:0] D1MidQ8   = 16'd7680;
  localparam logic [15:0] D1HighQ8  = 16'd15360;
  localparam logic [15:0] D2LimitQ8 = 16'd512;
  localparam logic [2:0]  SegLast   = 3'd7;

  // floor(h / 25) = (h * RecipBy25) >> 21 for any 16-bit h
  localparam logic [32:0] RecipBy25 = 33'd83887;
  // floor(y / 15) = (y * RecipBy15) >> 35 for any 32-bit y
  localparam logic [63:0] RecipBy15 = 64'h0000_0000_8888_8889;

  // curve points in 0.5 dB; rows 15, 30, 60 km; columns d2 = 0..8 km
  localparam logic signed [7:0] CurveTab [3][9] = '{
    '{ 8'sd8,  -8'sd26, -8'sd35, -8'sd35, -8'sd30, -8'sd25, -8'sd20, -8'sd16, -8'sd12},
    '{ 8'sd24, -8'sd17, -8'sd26, -8'sd24, -8'sd20, -8'sd16, -8'sd13, -8'sd10, -8'sd8 },
    '{ 8'sd40, -8'sd8,  -8'sd13, -8'sd12, -8'sd9,  -8'sd7,  -8'sd5,  -8'sd4,  -8'sd2 }
  };

  // floor(r * 2^25 / 25) for the remainder r of h / 25
  localparam logic [24:0] FracTab [25] = '{
    25'(0 * 33554432 / 25),  25'(1 * 33554432 / 25),  25'(2 * 33554432 / 25),
    25'(3 * 33554432 / 25),  25'(4 * 33554432 / 25),  25'(5 * 33554432 / 25),
    25'(6 * 33554432 / 25),  25'(7 * 33554432 / 25),  25'(8 * 33554432 / 25),
    25'(9 * 33554432 / 25),  25'(10 * 33554432 / 25), 25'(11 * 33554432 / 25),
    25'(12 * 33554432 / 25), 25'(13 * 33554432 / 25), 25'(14 * 33554432 / 25),
    25'(15 * 33554432 / 25), 25'(16 * 33554432 / 25), 25'(17 * 33554432 / 25),
    25'(18 * 33554432 / 25), 25'(19 * 33554432 / 25), 25'(20 * 33554432 / 25),
    25'(21 * 33554432 / 25), 25'(22 * 33554432 / 25), 25'(23 * 33554432 / 25),
    25'(24 * 33554432 / 25)
  };

  typedef struct packed {
    logic lo;   // d1 at or below 15 km
    logic hi;   // d1 at or above 60 km
    logic d2;   // d2 beyond 2 km
  } lim_t;

  typedef struct packed {
    logic [2:0]         seg;
    logic [15:0]        frac;
    logic               row;
    logic signed [16:0] dd;
    lim_t               lim;
    logic [11:0]        q0;
    logic [15:0]        h;
  } s1_t;

  typedef struct packed {
    logic signed [19:0] c1;
    logic signed [19:0] c2;
    logic signed [16:0] dd;
    logic               row;
    lim_t               lim;
    logic [39:0]        x;
  } s2_t;

  typedef struct packed {
    logic signed [19:0] c1;
    logic signed [19:0] c2;
    logic signed [37:0] pdd;
    logic               row;
    lim_t               lim;
  } s3_t;

  typedef struct packed {
    logic signed [37:0] num;
    logic               row;
  } side_t;

  typedef struct packed {
    logic [39:0] x;
    logic [21:0] rem;
    logic [19:0] root;
  } root_t;

  // curve value at lo + (hi - lo) * frac, in 1/512 dB
  function automatic logic signed [19:0] curve_val(logic signed [7:0] lo,
                                                   logic signed [7:0] hi,
                                                   logic [15:0] frac);
    logic signed [26:0] diff;
    logic signed [26:0] fr;
    logic signed [26:0] acc;
    diff = 27'(hi) - 27'(lo);
    fr   = signed'({11'd0, frac});
    acc  = (27'(lo) <<< 8) + diff * fr;
    return acc[19:0];
  endfunction

endpackage

### sv/irc_root_slice.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_root_slice
// Four digit-by-digit steps of the integer square root, one root bit a step.
// ----------------------------------------------------------------------------
module irc_root_slice (
  input  irc_pkg::root_t st_i,
  output irc_pkg::root_t st_o
);
  import irc_pkg::*;

  always_comb begin : root_steps
    logic [39:0] x;
    logic [21:0] rem;
    logic [19:0] root;
    logic [23:0] tv;
    logic [23:0] trial;
    x    = st_i.x;
    rem  = st_i.rem;
    root = st_i.root;
    tv   = '0;
    trial = '0;
    for (int i = 0; i < RootSteps; i++) begin
      tv    = {rem, x[39:38]};
      trial = {2'b00, root, 2'b01};
      x     = {x[37:0], 2'b00};
      if (tv >= trial) begin
        rem  = 22'(tv - trial);
        root = {root[18:0], 1'b1};
      end else begin
        rem  = tv[21:0];
        root = {root[18:0], 1'b0};
      end
    end
    st_o.x    = x;
    st_o.rem  = rem;
    st_o.root = root;
  end

endmodule

### sv/isolated_ridge_correction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isolated_ridge_correction
// Ridge correction in 1/256 dB from two horizon distances and a ridge height.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat is taken every cycle while the output is not
// stalled. The depth is set by the square root of the height term, five
// register stages of four root bits each, followed by a split 19x37
// multiply, the rounding shift and a multiply-by-reciprocal divide by 15.
// A stall on the output holds only the stages behind it; empty stages keep
// filling.
// ----------------------------------------------------------------------------
module isolated_ridge_correction (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        d1_km_i,
  input  logic [15:0]        d2_km_i,
  input  logic [15:0]        ridge_height_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] correction_db_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import irc_pkg::*;

  logic                 v2_q;
  logic [NumStages:1]   v_q;
  logic [NumStages:1]   rdy;

  s1_t                  s1_d, s1_q;
  s2_t                  s2_d, s2_q;
  s3_t                  s3_d, s3_q;
  side_t                side_d;
  side_t                side_q [RootSlices-1];
  root_t                sq_in  [RootSlices];
  root_t                sq_out [RootSlices];
  root_t                sq_q   [RootSlices];
  logic [37:0]          pl_d, pl_q;
  logic [36:0]          ph_d, ph_q;
  logic                 neg8_q, row8_q, neg9_q, neg10_q;
  logic [31:0]          y_d, y_q;
  logic [28:0]          mag_d, mag_q;
  logic signed [23:0]   out_d, out_q;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegIdxV2) ? {31'd0, v2_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == RegIdxV2)) begin
      v2_q <= pwdata[0];
    end
  end

  // flow control
  always_comb begin
    rdy[NumStages] = !v_q[NumStages] || !out_stall_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[StgIn];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[StgIn]) begin
        v_q[StgIn] <= in_valid_i;
      end
      for (int k = StgIn + 1; k <= NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: segment, offsets, h / 25
  always_comb begin : stage1
    logic [15:0] d2m1;
    logic [32:0] hmul;
    d2m1 = d2_km_i - 16'd1;
    if (d2_km_i == '0) begin
      s1_d.seg = '0;
    end else if (d2m1[15:8] > 8'(SegLast)) begin
      s1_d.seg = SegLast;
    end else begin
      s1_d.seg = d2m1[10:8];
    end
    s1_d.frac   = d2_km_i - {5'd0, s1_d.seg, 8'd0};
    s1_d.row    = d1_km_i >= D1MidQ8;
    s1_d.dd     = signed'({1'b0, d1_km_i}) -
                  signed'({1'b0, (s1_d.row ? D1MidQ8 : D1LowQ8)});
    s1_d.lim.lo = d1_km_i <= D1LowQ8;
    s1_d.lim.hi = d1_km_i >= D1HighQ8;
    s1_d.lim.d2 = d2_km_i > D2LimitQ8;
    hmul        = 33'(ridge_height_i) * RecipBy25;
    s1_d.q0     = hmul[32:21];
    s1_d.h      = ridge_height_i;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StgIn]) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: curve lookups, radicand
  always_comb begin : stage2
    logic [1:0]  ri;
    logic [3:0]  si;
    logic [15:0] rfull;
    ri    = {1'b0, s1_q.row};
    si    = {1'b0, s1_q.seg};
    rfull = s1_q.h - 16'({4'd0, s1_q.q0} * 16'd25);
    s2_d.c1  = curve_val(CurveTab[ri][si], CurveTab[ri][si+4'd1], s1_q.frac);
    s2_d.c2  = curve_val(CurveTab[ri+2'd1][si], CurveTab[ri+2'd1][si+4'd1], s1_q.frac);
    s2_d.dd  = s1_q.dd;
    s2_d.row = s1_q.row;
    s2_d.lim = s1_q.lim;
    s2_d.x   = {3'd0, s1_q.q0, 25'd0} + {15'd0, FracTab[rfull[4:0]]};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StgCurve]) begin
      s2_q <= s2_d;
    end
  end

  // stage 3: slope times first-distance offset
  always_comb begin : stage3
    logic signed [20:0] dc;
    dc        = 21'(s2_q.c2) - 21'(s2_q.c1);
    s3_d.c1   = s2_q.c1;
    s3_d.c2   = s2_q.c2;
    s3_d.pdd  = 38'(dc) * 38'(s2_q.dd);
    s3_d.row  = s2_q.row;
    s3_d.lim  = s2_q.lim;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[RootFirst]) begin
      s3_q <= s3_d;
    end
  end

  // stage 4: numerator and corrected-mode limits
  always_comb begin : stage4
    logic signed [37:0] c1e, c2e, c1den, c2den, num;
    c1e   = 38'(s3_q.c1);
    c2e   = 38'(s3_q.c2);
    c1den = s3_q.row ? (((c1e <<< 4) - c1e) <<< 9) : (((c1e <<< 4) - c1e) <<< 8);
    c2den = s3_q.row ? (((c2e <<< 4) - c2e) <<< 9) : (((c2e <<< 4) - c2e) <<< 8);
    num   = c1den + s3_q.pdd;
    if (v2_q) begin
      if (s3_q.lim.lo) begin
        num = c1den;
      end else if (s3_q.lim.hi) begin
        num = c2den;
      end
      if (s3_q.lim.d2 && !num[37] && (num != '0)) begin
        num = '0;
      end
    end
    side_d.num = num;
    side_d.row = s3_q.row;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StgSide]) begin
      side_q[0] <= side_d;
    end
  end

  for (genvar k = 1; k < RootSlices - 1; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (rdy[StgSide+k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // stages 3..7: square root of the height term
  assign sq_in[0] = '{x: s2_q.x, rem: '0, root: '0};

  for (genvar g = 0; g < RootSlices; g++) begin : g_root
    if (g > 0) begin : g_chain
      assign sq_in[g] = sq_q[g-1];
    end
    irc_root_slice u_slice (
      .st_i (sq_in[g]),
      .st_o (sq_out[g])
    );
    always_ff @(posedge clk_i) begin
      if (rdy[RootFirst+g]) begin
        sq_q[g] <= sq_out[g];
      end
    end
  end

  // stage 8: split product alpha * |num|
  always_comb begin : stage8
    logic [37:0] mabs;
    logic [18:0] alpha;
    alpha = sq_q[RootSlices-1].root[18:0];
    mabs  = side_q[RootSlices-2].num[37] ? 38'(-side_q[RootSlices-2].num)
                                         : side_q[RootSlices-2].num;
    pl_d  = 38'(alpha) * 38'(mabs[18:0]);
    ph_d  = 37'(alpha) * 37'(mabs[36:19]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StgMul]) begin
      pl_q   <= pl_d;
      ph_q   <= ph_d;
      neg8_q <= side_q[RootSlices-2].num[37];
      row8_q <= side_q[RootSlices-2].row;
    end
  end

  // stage 9: sum, round half away, shift by 2^(25+row)
  always_comb begin : stage9
    logic [56:0] m;
    m = (57'(ph_q) << 19) + 57'(pl_q);
    m = m + (row8_q ? (57'd15 << 25) : (57'd15 << 24));
    y_d = row8_q ? {1'b0, m[56:26]} : m[56:25];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StgSum]) begin
      y_q    <= y_d;
      neg9_q <= neg8_q;
    end
  end

  // stage 10: divide by 15
  always_comb begin : stage10
    logic [63:0] p;
    p     = 64'(y_q) * RecipBy15;
    mag_d = p[63:35];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StgDiv]) begin
      mag_q   <= mag_d;
      neg10_q <= neg9_q;
    end
  end

  // stage 11: sign and saturation
  always_comb begin
    if (neg10_q) begin
      out_d = (mag_q >= 29'h80_0000) ? 24'sh80_0000 : 24'(-mag_q);
    end else begin
      out_d = (mag_q >= 29'h80_0000) ? 24'sh7F_FFFF : signed'(mag_q[23:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NumStages]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o     = v_q[NumStages];
  assign correction_db_o = out_q;

endmodule

### sv/irc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_checker
// Port-level checks of the isolated ridge correction block, bound to its top.
// ----------------------------------------------------------------------------
module irc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [15:0]        d1_km_i,
  input logic [15:0]        d2_km_i,
  input logic [15:0]        ridge_height_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [23:0] correction_db_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [2:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);
  import irc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(correction_db_o))
    else $error("result beat changed under stall");

  // an empty output stage means the whole pipe can move
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  // mode register reads back the last write
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == RegIdxV2)
    |=> (paddr[2] != RegIdxV2) || (prdata[0] == $past(pwdata[0])))
    else $error("mode register readback mismatch");

  // inputs observed only to keep the bind port list complete
  logic unused_ok;
  assign unused_ok = in_valid_i ^ (^d1_km_i) ^ (^d2_km_i) ^ (^ridge_height_i);

endmodule

bind isolated_ridge_correction irc_checker u_irc_checker (.*);
